// ===== rtl/cc3p_pkg.sv =====
`timescale 1ns / 1ps
package cc3p_pkg;

  localparam int CW = 20;            // input coordinate width
  localparam int DW = CW + 1;        // coordinate difference width
  localparam int SW = 2 * DW;        // product of two differences
  localparam int PW = SW + 1;        // determinant and squared lengths
  localparam int EW = PW + 1;        // denominator, 2*det
  localparam int TW = DW + PW;       // numerator partial products
  localparam int NW = TW + 2;        // numerator, signed
  localparam int MW = NW - 1;        // numerator magnitude, quotient bits
  localparam int OW = 32;            // center coordinate width
  localparam int LAT = 6 + MW + 1;   // start to out_valid, in cycles

  localparam logic signed [NW-1:0] OMAX = NW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [NW-1:0] OMIN = -OMAX - NW'(1);

  typedef struct packed {
    logic coll;
    logic negx;
    logic negy;
  } div_ctl_t;

endpackage

// ===== rtl/circle_center_from_three_points_top.sv =====
`timescale 1ns / 1ps
// Channel  | Ports                                   | Dir | Transfer
// input    | in_ax in_ay in_bx in_by in_cx in_cy     | in  | start & !busy
// result   | out_center_x out_center_y out_collinear | out | out_valid, one cycle
//          | out_saturated                           |     |
// One triplet enters per cycle; busy stays low, so start is always taken.
// The pipeline has six arithmetic stages, 65 divider stages (one quotient
// bit each, restoring division of the 65-bit numerator magnitude), one clip stage.
// Synchronous active-low reset clears the valid bits of all stages.
// The receiver cannot stall, so the pipeline never holds.
module circle_center_from_three_points_top
  import cc3p_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_ax,
  input  logic signed [CW-1:0] in_ay,
  input  logic signed [CW-1:0] in_bx,
  input  logic signed [CW-1:0] in_by,
  input  logic signed [CW-1:0] in_cx,
  input  logic signed [CW-1:0] in_cy,
  output logic                 out_valid,
  output logic signed [OW-1:0] out_center_x,
  output logic signed [OW-1:0] out_center_y,
  output logic                 out_collinear,
  output logic                 out_saturated
);

  assign busy = 1'b0;

  // stage 1: differences relative to A
  logic                 v1_r;
  logic signed [DW-1:0] dbx1_r, dby1_r, dcx1_r, dcy1_r;
  logic signed [CW-1:0] ax1_r, ay1_r;
  // stage 2: products
  logic                 v2_r;
  logic signed [SW-1:0] mbc2_r, mcb2_r, qbx2_r, qby2_r, qcx2_r, qcy2_r;
  logic signed [DW-1:0] dbx2_r, dby2_r, dcx2_r, dcy2_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  // stage 3: determinant and squared lengths
  logic                 v3_r;
  logic signed [PW-1:0] det3_r, sb3_r, sc3_r;
  logic signed [DW-1:0] dbx3_r, dby3_r, dcx3_r, dcy3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  // stage 4: numerator terms
  logic                 v4_r, coll4_r;
  logic signed [TW-1:0] t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;
  logic signed [EW-1:0] den4_r;
  // stage 5: numerators
  logic                 v5_r, coll5_r;
  logic signed [NW-1:0] numx5_r, numy5_r;
  logic signed [EW-1:0] den5_r;
  // divider pipeline; entry 0 holds magnitudes and signs
  logic             dvld_r [0:MW];
  div_ctl_t         ctl_r  [0:MW];
  logic [EW-1:0]    dm_r   [0:MW];
  logic [MW-1:0]    nqx_r  [0:MW];
  logic [MW-1:0]    nqy_r  [0:MW];
  logic [EW-1:0]    remx_r [0:MW];
  logic [EW-1:0]    remy_r [0:MW];
  logic [MW-1:0]    nqx_nxt  [0:MW-1];
  logic [MW-1:0]    nqy_nxt  [0:MW-1];
  logic [EW-1:0]    remx_nxt [0:MW-1];
  logic [EW-1:0]    remy_nxt [0:MW-1];

  logic signed [TW-1:0] t1_nxt, t2_nxt, t3_nxt, t4_nxt, t5_nxt, t6_nxt;
  logic signed [EW-1:0] den_nxt;
  logic signed [NW-1:0] numx_nxt, numy_nxt;
  logic signed [NW-1:0] qx_s, qy_s;
  logic signed [OW-1:0] cx_nxt, cy_nxt;
  logic                 satx, saty;

  logic out_valid_r, out_coll_r, out_sat_r;
  logic signed [OW-1:0] out_cx_r, out_cy_r;

  always_comb begin
    den_nxt = {det3_r, 1'b0};
    t1_nxt  = dcy3_r * sb3_r;
    t2_nxt  = dby3_r * sc3_r;
    t3_nxt  = dbx3_r * sc3_r;
    t4_nxt  = dcx3_r * sb3_r;
    t5_nxt  = ax3_r * den_nxt;
    t6_nxt  = ay3_r * den_nxt;
    numx_nxt = NW'(t1_r) - NW'(t2_r) + NW'(t5_r);
    numy_nxt = NW'(t3_r) - NW'(t4_r) + NW'(t6_r);
  end

  // restoring division, one quotient bit per stage, MSB first
  always_comb begin
    logic [EW:0] shx, shy;
    for (int k = 0; k < MW; k++) begin
      nqx_nxt[k] = nqx_r[k];
      nqy_nxt[k] = nqy_r[k];
      shx = {remx_r[k], nqx_r[k][MW-1-k]};
      shy = {remy_r[k], nqy_r[k][MW-1-k]};
      if (shx >= {1'b0, dm_r[k]}) begin
        remx_nxt[k] = EW'(shx - {1'b0, dm_r[k]});
        nqx_nxt[k][MW-1-k] = 1'b1;
      end else begin
        remx_nxt[k] = EW'(shx);
        nqx_nxt[k][MW-1-k] = 1'b0;
      end
      if (shy >= {1'b0, dm_r[k]}) begin
        remy_nxt[k] = EW'(shy - {1'b0, dm_r[k]});
        nqy_nxt[k][MW-1-k] = 1'b1;
      end else begin
        remy_nxt[k] = EW'(shy);
        nqy_nxt[k][MW-1-k] = 1'b0;
      end
    end
  end

  // apply sign and clip
  always_comb begin
    qx_s = ctl_r[MW].negx ? -$signed({1'b0, nqx_r[MW]}) : $signed({1'b0, nqx_r[MW]});
    qy_s = ctl_r[MW].negy ? -$signed({1'b0, nqy_r[MW]}) : $signed({1'b0, nqy_r[MW]});
    satx = 1'b0;
    saty = 1'b0;
    cx_nxt = OW'(qx_s);
    cy_nxt = OW'(qy_s);
    if (qx_s > OMAX) begin
      cx_nxt = OW'(OMAX);
      satx   = 1'b1;
    end else if (qx_s < OMIN) begin
      cx_nxt = OW'(OMIN);
      satx   = 1'b1;
    end
    if (qy_s > OMAX) begin
      cy_nxt = OW'(OMAX);
      saty   = 1'b1;
    end else if (qy_s < OMIN) begin
      cy_nxt = OW'(OMIN);
      saty   = 1'b1;
    end
    // collinear: drop the quotient
    if (ctl_r[MW].coll) begin
      cx_nxt = '0;
      cy_nxt = '0;
      satx   = 1'b0;
      saty   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int k = 0; k <= MW; k++) begin
        dvld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      dvld_r[0] <= v5_r;
      for (int k = 0; k < MW; k++) begin
        dvld_r[k+1] <= dvld_r[k];
      end
      out_valid_r <= dvld_r[MW];
    end
  end

  always_ff @(posedge clk) begin
    dbx1_r <= DW'(in_bx) - DW'(in_ax);
    dby1_r <= DW'(in_by) - DW'(in_ay);
    dcx1_r <= DW'(in_cx) - DW'(in_ax);
    dcy1_r <= DW'(in_cy) - DW'(in_ay);
    ax1_r  <= in_ax;
    ay1_r  <= in_ay;

    mbc2_r <= dbx1_r * dcy1_r;
    mcb2_r <= dby1_r * dcx1_r;
    qbx2_r <= dbx1_r * dbx1_r;
    qby2_r <= dby1_r * dby1_r;
    qcx2_r <= dcx1_r * dcx1_r;
    qcy2_r <= dcy1_r * dcy1_r;
    dbx2_r <= dbx1_r;
    dby2_r <= dby1_r;
    dcx2_r <= dcx1_r;
    dcy2_r <= dcy1_r;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;

    det3_r <= PW'(mbc2_r) - PW'(mcb2_r);
    sb3_r  <= PW'(qbx2_r) + PW'(qby2_r);
    sc3_r  <= PW'(qcx2_r) + PW'(qcy2_r);
    dbx3_r <= dbx2_r;
    dby3_r <= dby2_r;
    dcx3_r <= dcx2_r;
    dcy3_r <= dcy2_r;
    ax3_r  <= ax2_r;
    ay3_r  <= ay2_r;

    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    t3_r    <= t3_nxt;
    t4_r    <= t4_nxt;
    t5_r    <= t5_nxt;
    t6_r    <= t6_nxt;
    den4_r  <= den_nxt;
    coll4_r <= (det3_r == '0);

    numx5_r <= numx_nxt;
    numy5_r <= numy_nxt;
    den5_r  <= den4_r;
    coll5_r <= coll4_r;

    ctl_r[0].coll <= coll5_r;
    ctl_r[0].negx <= numx5_r[NW-1] ^ den5_r[EW-1];
    ctl_r[0].negy <= numy5_r[NW-1] ^ den5_r[EW-1];
    dm_r[0]   <= den5_r[EW-1] ? EW'(-den5_r) : EW'(den5_r);
    nqx_r[0]  <= numx5_r[NW-1] ? MW'(-numx5_r) : MW'(numx5_r);
    nqy_r[0]  <= numy5_r[NW-1] ? MW'(-numy5_r) : MW'(numy5_r);
    remx_r[0] <= '0;
    remy_r[0] <= '0;

    for (int k = 0; k < MW; k++) begin
      ctl_r[k+1]  <= ctl_r[k];
      dm_r[k+1]   <= dm_r[k];
      nqx_r[k+1]  <= nqx_nxt[k];
      nqy_r[k+1]  <= nqy_nxt[k];
      remx_r[k+1] <= remx_nxt[k];
      remy_r[k+1] <= remy_nxt[k];
    end

    out_cx_r   <= cx_nxt;
    out_cy_r   <= cy_nxt;
    out_coll_r <= ctl_r[MW].coll;
    out_sat_r  <= satx | saty;
  end

  assign out_valid     = out_valid_r;
  assign out_center_x  = out_cx_r;
  assign out_center_y  = out_cy_r;
  assign out_collinear = out_coll_r;
  assign out_saturated = out_sat_r;

  a_coll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_collinear) |-> (out_center_x == '0 && out_center_y == '0))
    else $error("collinear result with nonzero center");

  a_coll_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_collinear) |-> !out_saturated)
    else $error("collinear result flagged saturated");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_center_x == OW'(OMAX) || out_center_x == OW'(OMIN) ||
       out_center_y == OW'(OMAX) || out_center_y == OW'(OMIN)))
    else $error("saturated flag without a clipped coordinate");

  a_entry_reach: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !coll5_r) |-> (den5_r != '0))
    else $error("zero denominator entering divider on non-collinear item");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench
  import cc3p_pkg::*;
();

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  } triplet_t;

  typedef struct {
    logic signed [OW-1:0] center_x, center_y;
    logic                 collinear, saturated;
  } center_t;

  localparam int WATCHDOG_CYCLES = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] in_ax = '0, in_ay = '0, in_bx = '0, in_by = '0, in_cx = '0, in_cy = '0;
  logic                 out_valid;
  logic signed [OW-1:0] out_center_x, out_center_y;
  logic                 out_collinear, out_saturated;

  triplet_t pending_triplets[$];
  center_t  expected_centers[$];
  int       idle_pct = 0;
  int       mismatches = 0;
  int       centers_seen = 0;
  int       collinear_seen = 0;
  int       saturated_seen = 0;
  int       quiet_cycles = 0;
  bit       hold_valid = 0;
  triplet_t held;

  circle_center_from_three_points_top dut (.*);

  always #5 clk = ~clk;

  // Clip a wide quotient to the output range.
  function automatic logic signed [OW-1:0] clip_center(input logic signed [127:0] v,
                                                       inout logic sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (OW - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) begin
      sat = 1'b1;
      return hi[OW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[OW-1:0];
    end
    return v[OW-1:0];
  endfunction

  function automatic center_t circumcenter(input triplet_t t);
    logic signed [127:0] bx, by, cx, cy, det, sb, sc, den, numx, numy;
    center_t r;
    logic sat;
    bx = 128'(t.bx) - 128'(t.ax);
    by = 128'(t.by) - 128'(t.ay);
    cx = 128'(t.cx) - 128'(t.ax);
    cy = 128'(t.cy) - 128'(t.ay);
    det = bx * cy - by * cx;
    sat = 1'b0;
    r.collinear = 1'b0;
    if (det == 0) begin
      r.center_x = '0;
      r.center_y = '0;
      r.collinear = 1'b1;
      r.saturated = 1'b0;
      return r;
    end
    sb = bx * bx + by * by;
    sc = cx * cx + cy * cy;
    den = det + det;
    numx = cy * sb - by * sc + 128'(t.ax) * den;
    numy = bx * sc - cx * sb + 128'(t.ay) * den;
    // SV signed division truncates toward zero
    r.center_x = clip_center(numx / den, sat);
    r.center_y = clip_center(numy / den, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      1: return CW'($signed($urandom_range(0, 64)) - 32);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic push_triplet(input int ax, ay, bx, by, cx, cy);
    triplet_t t;
    t.ax = CW'(ax); t.ay = CW'(ay); t.bx = CW'(bx);
    t.by = CW'(by); t.cx = CW'(cx); t.cy = CW'(cy);
    pending_triplets.push_back(t);
  endtask

  task automatic push_random();
    triplet_t t;
    int k, dx, dy;
    t.ax = rand_coord(); t.ay = rand_coord();
    t.bx = rand_coord(); t.by = rand_coord();
    t.cx = rand_coord(); t.cy = rand_coord();
    case ($urandom_range(0, 9))
      0: begin  // collinear: C on line AB
        k = $urandom_range(0, 6) - 3;
        dx = $urandom_range(0, 2000) - 1000;
        dy = $urandom_range(0, 2000) - 1000;
        t.bx = t.ax + CW'(dx); t.by = t.ay + CW'(dy);
        t.cx = t.ax + CW'(k * dx); t.cy = t.ay + CW'(k * dy);
      end
      1: begin  // nearly collinear: far center
        dx = $urandom_range(1, 5000);
        t.bx = t.ax + CW'(dx); t.by = t.ay;
        t.cx = t.ax + CW'(2 * dx); t.cy = t.ay + CW'($urandom_range(0, 2) - 1);
      end
      2: begin  // small triangle near A
        t.bx = t.ax + CW'($signed($urandom_range(0, 16)) - 8);
        t.by = t.ay + CW'($signed($urandom_range(0, 16)) - 8);
        t.cx = t.ax + CW'($signed($urandom_range(0, 16)) - 8);
        t.cy = t.ay + CW'($signed($urandom_range(0, 16)) - 8);
      end
      default: ;
    endcase
    pending_triplets.push_back(t);
  endtask

  // Driver: change inputs at the falling edge, hold until the transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_valid && start && !busy) hold_valid = 0;
      if (!hold_valid && pending_triplets.size() > 0 &&
          $urandom_range(0, 99) >= idle_pct) begin
        held = pending_triplets.pop_front();
        hold_valid = 1;
      end
      start <= hold_valid;
      if (hold_valid) begin
        in_ax <= held.ax; in_ay <= held.ay; in_bx <= held.bx;
        in_by <= held.by; in_cx <= held.cx; in_cy <= held.cy;
      end
    end
  end

  // Monitor: record transfers and check results at the rising edge.
  always @(posedge clk) begin
    triplet_t t;
    center_t  e;
    bit       moved;
    moved = 0;
    if (rst_n && start && !busy) begin
      t.ax = in_ax; t.ay = in_ay; t.bx = in_bx;
      t.by = in_by; t.cx = in_cx; t.cy = in_cy;
      expected_centers.push_back(circumcenter(t));
      moved = 1;
    end
    if (rst_n && out_valid) begin
      moved = 1;
      centers_seen++;
      if (out_collinear) collinear_seen++;
      if (out_saturated) saturated_seen++;
      if (expected_centers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no triplet pending");
      end else begin
        e = expected_centers.pop_front();
        if (out_center_x !== e.center_x || out_center_y !== e.center_y ||
            out_collinear !== e.collinear || out_saturated !== e.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: center exp (%0d,%0d) col %b sat %b, got (%0d,%0d) col %b sat %b",
                     e.center_x, e.center_y, e.collinear, e.saturated,
                     out_center_x, out_center_y, out_collinear, out_saturated);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase_pct[4] = '{0, 72, 0, 25};
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Directed: extremes, collinear and coincident points, axis-aligned chords.
    push_triplet(0, 0, 0, 0, 0, 0);
    push_triplet(5, 7, 5, 7, 100, 3);
    push_triplet(0, 0, 10, 0, 20, 0);
    push_triplet(0, 0, 0, 10, 10, 0);
    push_triplet(0, 0, 100, 0, 100, 100);
    push_triplet(0, 0, 0, 100, 100, 100);
    push_triplet(-1, -1, 1, -1, -1, 1);
    push_triplet(0, 0, 1, 0, 2, 1);
    push_triplet(0, 0, 1, 0, 3, 1);
    push_triplet(-524288, -524288, 524287, 524287, -524288, 524287);
    push_triplet(524287, 524287, -524288, -524288, 524287, -524288);
    push_triplet(-524288, 0, 524287, 0, 0, 1);
    push_triplet(0, -524288, 0, 524287, 1, 0);
    push_triplet(-524288, -524288, 524287, -524287, -524288 + 2, -524288 + 1);
    push_triplet(524287, -524288, -524288, 524287, 524287, 524287);
    push_triplet(-3, 4, 3, -4, 5, 0);
    push_triplet(1000, -2000, -3000, 7000, 12345, -54321);
    push_triplet(-524288, -524288, -524288, -524288, 524287, 524287);
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      repeat (200) push_random();
      wait (pending_triplets.size() == 0 && !hold_valid);
    end
    wait (expected_centers.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("Covered %0d centers, %0d collinear, %0d saturated, over four idling phases.",
             centers_seen, collinear_seen, saturated_seen);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
